/* design/lav_pkg.sv */
// Shared constants and the per-item context bundle for the look-at view matrix block.
// No dependencies.
`timescale 1ns / 1ps

package lav_pkg;

    localparam int IN_BITS   = 32;            // input coordinate width
    localparam int DIR_W     = IN_BITS + 1;   // to - from
    localparam int MG_W      = 30;            // normalized magnitude, top bit 2^29
    localparam int SUM_W     = 2 * MG_W + 2;  // sum of three squares
    localparam int LEN_W     = MG_W + 1;      // floor(sqrt(sum))
    localparam int ISQ_STEPS = MG_W + 1;      // one root bit per step
    localparam int SH_W      = 6;             // msb index of a DIR_W word

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd3;

    // vector 0 is up, vector 1 is forward
    typedef struct packed {
        logic [2:0][IN_BITS-1:0]      from;
        logic [1:0][2:0]              sgn;
        logic [1:0]                   zero;
        logic [1:0][2:0][MG_W-1:0]    mg;
    } ctx_t;

endpackage

/* design/look_at_view_matrix_top.sv */
// Look-at view matrix builder: normalize, two cross products, translation column.
// Depends on lav_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid / in_stall carry one camera (from, to, up) per beat,
//   all signed Q16.16. Output channel: out_valid / out_stall carry one matrix
//   row per beat, rows 0..3 in order; last_row marks row 3.
//   Row 0 leaves once the item has passed every pipeline stage; rows 1..3
//   follow it back to back while out_stall is low.
//   Throughput: the output port emits one row per cycle while out_stall
//   is low. The pipeline takes a new item every cycle while the row
//   buffer is free or is handing out its last row.
//   Pipeline: magnitude and shift stages, a 16-stage square root at two root
//   bits per stage, a restoring divider at two quotient bits per stage, then
//   cross-product and translation stages.
//   Stall: out_stall freezes the row buffer; once it is full the whole
//   pipeline holds and in_stall rises. Nothing is dropped or repeated.
//   Reset (rst_n low, async) empties every stage and the row buffer.

module look_at_view_matrix_top
    import lav_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [IN_BITS-1:0]    from_x,
    input  logic signed [IN_BITS-1:0]    from_y,
    input  logic signed [IN_BITS-1:0]    from_z,
    input  logic signed [IN_BITS-1:0]    to_x,
    input  logic signed [IN_BITS-1:0]    to_y,
    input  logic signed [IN_BITS-1:0]    to_z,
    input  logic signed [IN_BITS-1:0]    up_x,
    input  logic signed [IN_BITS-1:0]    up_y,
    input  logic signed [IN_BITS-1:0]    up_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   row_index,
    output logic signed [WORD_WIDTH-1:0] col_zero,
    output logic signed [WORD_WIDTH-1:0] col_one,
    output logic signed [WORD_WIDTH-1:0] col_two,
    output logic signed [WORD_WIDTH-1:0] col_three,
    output logic                         last_row
);

    localparam int UW        = FRAC_BITS + 2;   // unit vector component
    localparam int RW        = FRAC_BITS + 4;   // matrix row component
    localparam int QW        = FRAC_BITS + 1;   // quotient
    localparam int DVD_W     = MG_W + FRAC_BITS + 1;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int DIV_PER   = 2;
    localparam int DIV_STG   = (DIV_STEPS + DIV_PER - 1) / DIV_PER;
    localparam int ISQ_PER   = 2;
    localparam int ISQ_STG   = (ISQ_STEPS + ISQ_PER - 1) / ISQ_PER;
    localparam int P1_W      = 2 * UW;
    localparam int D1_W      = P1_W + 1;
    localparam int P2_W      = RW + UW;
    localparam int D2_W      = P2_W + 1;
    localparam int P3_W      = RW + IN_BITS;
    localparam int C3_W      = P3_W - FRAC_BITS + 1;
    localparam int RND_W     = ((D2_W > P3_W) ? D2_W : P3_W) + 2;
    localparam int SAT_W     = ((RND_W > WORD_WIDTH) ? RND_W : WORD_WIDTH) + 1;

    localparam logic [RND_W-1:0] RND_HALF =
        {{(RND_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [SAT_W-1:0] SAT_HI =
        {{(SAT_W-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [SAT_W-1:0] ONE_FX =
        {{(SAT_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    // shift right by FRAC_BITS, half away from zero
    function automatic logic signed [RND_W-1:0] rnd(input logic signed [RND_W-1:0] v);
        logic [RND_W-1:0] mag;
        logic [RND_W-1:0] r;
        mag = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
        r   = (mag + RND_HALF) >> FRAC_BITS;
        rnd = v[RND_W-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [WORD_WIDTH-1:0] sat(input logic signed [SAT_W-1:0] v);
        if (v > SAT_HI)
            sat = WORD_WIDTH'(SAT_HI);
        else if (v < SAT_LO)
            sat = WORD_WIDTH'(SAT_LO);
        else
            sat = WORD_WIDTH'(v);
    endfunction

    logic en;
    logic buf_valid_reg;
    logic [1:0] buf_row_reg;

    assign en       = !buf_valid_reg || (!out_stall && buf_row_reg == ROW_LAST);
    assign in_stall = !en;

    // ---------------- S1: operands, forward direction ----------------
    logic                      s1_v_reg;
    logic signed [IN_BITS-1:0] s1_from_reg [3];
    logic signed [IN_BITS-1:0] s1_up_reg [3];
    logic signed [DIR_W-1:0]   s1_dir_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_from_reg[0] <= from_x;
            s1_from_reg[1] <= from_y;
            s1_from_reg[2] <= from_z;
            s1_up_reg[0]   <= up_x;
            s1_up_reg[1]   <= up_y;
            s1_up_reg[2]   <= up_z;
            s1_dir_reg[0]  <= DIR_W'(to_x) - DIR_W'(from_x);
            s1_dir_reg[1]  <= DIR_W'(to_y) - DIR_W'(from_y);
            s1_dir_reg[2]  <= DIR_W'(to_z) - DIR_W'(from_z);
        end
    end

    // ---------------- S2: sign and magnitude ----------------
    logic                      s2_v_reg;
    logic signed [IN_BITS-1:0] s2_from_reg [3];
    logic [DIR_W-1:0]          s2_mag_reg [2][3];
    logic                      s2_sgn_reg [2][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s2_from_reg[j]   <= s1_from_reg[j];
                s2_sgn_reg[0][j] <= s1_up_reg[j][IN_BITS-1];
                s2_mag_reg[0][j] <= s1_up_reg[j][IN_BITS-1] ?
                                    DIR_W'(-DIR_W'(s1_up_reg[j])) : DIR_W'(s1_up_reg[j]);
                s2_sgn_reg[1][j] <= s1_dir_reg[j][DIR_W-1];
                s2_mag_reg[1][j] <= s1_dir_reg[j][DIR_W-1] ?
                                    DIR_W'(-s1_dir_reg[j]) : DIR_W'(s1_dir_reg[j]);
            end
        end
    end

    // ---------------- S3: leading one of the largest magnitude ----------------
    logic                      s3_v_reg;
    logic signed [IN_BITS-1:0] s3_from_reg [3];
    logic [DIR_W-1:0]          s3_mag_reg [2][3];
    logic                      s3_sgn_reg [2][3];
    logic [SH_W-1:0]           s3_msb_reg [2];
    logic                      s3_nz_reg [2];
    logic [SH_W-1:0]           s3_msb_next [2];
    logic                      s3_nz_next [2];

    // the msb of the OR equals the msb of the max
    always_comb
    begin
        logic [DIR_W-1:0] orv;
        for (int v = 0; v < 2; v++)
        begin
            orv = s2_mag_reg[v][0] | s2_mag_reg[v][1] | s2_mag_reg[v][2];
            s3_msb_next[v] = '0;
            for (int b = 0; b < DIR_W; b++)
            begin
                if (orv[b])
                    s3_msb_next[v] = SH_W'(b);
            end
            s3_nz_next[v] = |orv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (en)
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_from_reg <= s2_from_reg;
            s3_mag_reg  <= s2_mag_reg;
            s3_sgn_reg  <= s2_sgn_reg;
            s3_msb_reg  <= s3_msb_next;
            s3_nz_reg   <= s3_nz_next;
        end
    end

    // ---------------- S4: shift into [2^29, 2^30) ----------------
    logic s4_v_reg;
    ctx_t s4_ctx_reg;
    ctx_t s4_ctx_next;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            s4_ctx_next.from[j] = s3_from_reg[j];
        for (int v = 0; v < 2; v++)
        begin
            s4_ctx_next.zero[v] = !s3_nz_reg[v];
            for (int j = 0; j < 3; j++)
            begin
                s4_ctx_next.sgn[v][j] = s3_sgn_reg[v][j];
                if (s3_msb_reg[v] >= SH_W'(MG_W))
                    s4_ctx_next.mg[v][j] = MG_W'(s3_mag_reg[v][j] >>
                                           (s3_msb_reg[v] - SH_W'(MG_W - 1)));
                else
                    s4_ctx_next.mg[v][j] = MG_W'(s3_mag_reg[v][j] <<
                                           (SH_W'(MG_W - 1) - s3_msb_reg[v]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (en)
            s4_v_reg <= s3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s4_ctx_reg <= s4_ctx_next;
    end

    // ---------------- S5: squares ----------------
    logic              s5_v_reg;
    ctx_t              s5_ctx_reg;
    logic [2*MG_W-1:0] s5_sq_reg [2][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_v_reg <= 1'b0;
        else if (en)
            s5_v_reg <= s4_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_ctx_reg <= s4_ctx_reg;
            for (int v = 0; v < 2; v++)
                for (int j = 0; j < 3; j++)
                    s5_sq_reg[v][j] <= (2*MG_W)'(s4_ctx_reg.mg[v][j]) *
                                       (2*MG_W)'(s4_ctx_reg.mg[v][j]);
        end
    end

    // ---------------- integer square root, two root bits per stage ----------------
    logic             iq_v_reg   [ISQ_STG+1];
    ctx_t             iq_ctx_reg [ISQ_STG+1];
    logic [SUM_W:0]   iq_n_reg   [ISQ_STG+1][2];
    logic [SUM_W:0]   iq_r_reg   [ISQ_STG+1][2];

    // stage 0 holds the sum of squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iq_v_reg[0] <= 1'b0;
        else if (en)
            iq_v_reg[0] <= s5_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            iq_ctx_reg[0] <= s5_ctx_reg;
            for (int v = 0; v < 2; v++)
            begin
                iq_n_reg[0][v] <= (SUM_W+1)'(s5_sq_reg[v][0]) + (SUM_W+1)'(s5_sq_reg[v][1])
                                + (SUM_W+1)'(s5_sq_reg[v][2]);
                iq_r_reg[0][v] <= '0;
            end
        end
    end

    for (genvar s = 0; s < ISQ_STG; s++)
    begin : g_isq
        logic [SUM_W:0] n_next [2];
        logic [SUM_W:0] r_next [2];

        always_comb
        begin
            logic [SUM_W:0] bitv;
            logic [SUM_W:0] trial;
            for (int v = 0; v < 2; v++)
            begin
                n_next[v] = iq_n_reg[s][v];
                r_next[v] = iq_r_reg[s][v];
                for (int k = 0; k < ISQ_PER; k++)
                begin
                    if (s * ISQ_PER + k < ISQ_STEPS)
                    begin
                        bitv  = {{SUM_W{1'b0}}, 1'b1} << (2 * (ISQ_STEPS - 1 - (s * ISQ_PER + k)));
                        trial = r_next[v] + bitv;
                        if (n_next[v] >= trial)
                        begin
                            n_next[v] = n_next[v] - trial;
                            r_next[v] = (r_next[v] >> 1) + bitv;
                        end
                        else
                        begin
                            r_next[v] = r_next[v] >> 1;
                        end
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                iq_v_reg[s+1] <= 1'b0;
            else if (en)
                iq_v_reg[s+1] <= iq_v_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                iq_ctx_reg[s+1] <= iq_ctx_reg[s];
                iq_n_reg[s+1]   <= n_next;
                iq_r_reg[s+1]   <= r_next;
            end
        end
    end

    // ---------------- restoring divider, two quotient bits per stage ----------------
    logic             dv_v_reg   [DIV_STG+1];
    ctx_t             dv_ctx_reg [DIV_STG+1];
    logic [LEN_W-1:0] dv_len_reg [DIV_STG+1][2];
    logic [DVD_W-1:0] dv_rem_reg [DIV_STG+1][2][3];
    logic [QW-1:0]    dv_q_reg   [DIV_STG+1][2][3];

    // stage 0: dividend = (mg << FRAC_BITS) + len/2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (en)
            dv_v_reg[0] <= iq_v_reg[ISQ_STG];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_ctx_reg[0] <= iq_ctx_reg[ISQ_STG];
            for (int v = 0; v < 2; v++)
            begin
                dv_len_reg[0][v] <= LEN_W'(iq_r_reg[ISQ_STG][v]);
                for (int j = 0; j < 3; j++)
                begin
                    dv_rem_reg[0][v][j] <= (DVD_W'(iq_ctx_reg[ISQ_STG].mg[v][j]) << FRAC_BITS)
                                         + DVD_W'(iq_r_reg[ISQ_STG][v][LEN_W-1:1]);
                    dv_q_reg[0][v][j]   <= '0;
                end
            end
        end
    end

    for (genvar s = 0; s < DIV_STG; s++)
    begin : g_div
        logic [DVD_W-1:0] rem_next [2][3];
        logic [QW-1:0]    q_next   [2][3];

        always_comb
        begin
            logic [DVD_W:0] cmp;
            for (int v = 0; v < 2; v++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    rem_next[v][j] = dv_rem_reg[s][v][j];
                    q_next[v][j]   = dv_q_reg[s][v][j];
                    for (int k = 0; k < DIV_PER; k++)
                    begin
                        if (s * DIV_PER + k < DIV_STEPS)
                        begin
                            cmp = (DVD_W+1)'(dv_len_reg[s][v]) << (FRAC_BITS - (s * DIV_PER + k));
                            if ((DVD_W+1)'(rem_next[v][j]) >= cmp)
                            begin
                                rem_next[v][j] = DVD_W'((DVD_W+1)'(rem_next[v][j]) - cmp);
                                q_next[v][j][FRAC_BITS - (s * DIV_PER + k)] = 1'b1;
                            end
                        end
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[s+1] <= 1'b0;
            else if (en)
                dv_v_reg[s+1] <= dv_v_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_ctx_reg[s+1] <= dv_ctx_reg[s];
                dv_len_reg[s+1] <= dv_len_reg[s];
                dv_rem_reg[s+1] <= rem_next;
                dv_q_reg[s+1]   <= q_next;
            end
        end
    end

    // ---------------- U: signed unit vectors ----------------
    logic                      u_v_reg;
    logic signed [IN_BITS-1:0] u_from_reg [3];
    logic signed [UW-1:0]      u_unit_reg [2][3];
    logic signed [UW-1:0]      u_unit_next [2][3];

    always_comb
    begin
        logic signed [UW-1:0] qs;
        for (int v = 0; v < 2; v++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                qs = $signed(UW'(dv_q_reg[DIV_STG][v][j]));
                if (dv_ctx_reg[DIV_STG].zero[v])
                    u_unit_next[v][j] = '0;
                else if (dv_ctx_reg[DIV_STG].sgn[v][j])
                    u_unit_next[v][j] = -qs;
                else
                    u_unit_next[v][j] = qs;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            u_v_reg <= 1'b0;
        else if (en)
            u_v_reg <= dv_v_reg[DIV_STG];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_unit_reg <= u_unit_next;
            for (int j = 0; j < 3; j++)
                u_from_reg[j] <= $signed(dv_ctx_reg[DIV_STG].from[j]);
        end
    end

    // ---------------- X1..X3: left = forward x up ----------------
    logic                      x1_v_reg, x2_v_reg, x3_v_reg;
    logic signed [IN_BITS-1:0] x1_from_reg [3];
    logic signed [IN_BITS-1:0] x2_from_reg [3];
    logic signed [IN_BITS-1:0] x3_from_reg [3];
    logic signed [UW-1:0]      x1_fwd_reg [3];
    logic signed [UW-1:0]      x2_fwd_reg [3];
    logic signed [UW-1:0]      x3_fwd_reg [3];
    logic signed [P1_W-1:0]    x1_p_reg [6];
    logic signed [D1_W-1:0]    x2_raw_reg [3];
    logic signed [RW-1:0]      x3_r0_reg [3];
    logic signed [RW-1:0]      x3_r0_next [3];
    logic                      x2_degen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_v_reg <= 1'b0;
            x2_v_reg <= 1'b0;
            x3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            x1_v_reg <= u_v_reg;
            x2_v_reg <= x1_v_reg;
            x3_v_reg <= x2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_from_reg <= u_from_reg;
            x1_fwd_reg  <= u_unit_reg[1];
            x1_p_reg[0] <= P1_W'(u_unit_reg[1][1]) * P1_W'(u_unit_reg[0][2]);
            x1_p_reg[1] <= P1_W'(u_unit_reg[1][2]) * P1_W'(u_unit_reg[0][1]);
            x1_p_reg[2] <= P1_W'(u_unit_reg[1][2]) * P1_W'(u_unit_reg[0][0]);
            x1_p_reg[3] <= P1_W'(u_unit_reg[1][0]) * P1_W'(u_unit_reg[0][2]);
            x1_p_reg[4] <= P1_W'(u_unit_reg[1][0]) * P1_W'(u_unit_reg[0][1]);
            x1_p_reg[5] <= P1_W'(u_unit_reg[1][1]) * P1_W'(u_unit_reg[0][0]);

            x2_from_reg <= x1_from_reg;
            x2_fwd_reg  <= x1_fwd_reg;
            for (int i = 0; i < 3; i++)
                x2_raw_reg[i] <= D1_W'(x1_p_reg[2*i]) - D1_W'(x1_p_reg[2*i+1]);

            x3_from_reg <= x2_from_reg;
            x3_fwd_reg  <= x2_fwd_reg;
            x3_r0_reg   <= x3_r0_next;
        end
    end

    // parallel to the cross product, up becomes (0,0,1): left = (fwd.y, -fwd.x, 0)
    assign x2_degen = (x2_raw_reg[0] == '0) && (x2_raw_reg[1] == '0) && (x2_raw_reg[2] == '0);

    always_comb
    begin
        if (x2_degen)
        begin
            x3_r0_next[0] = RW'(x2_fwd_reg[1]);
            x3_r0_next[1] = -RW'(x2_fwd_reg[0]);
            x3_r0_next[2] = '0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                x3_r0_next[i] = RW'(rnd(RND_W'(x2_raw_reg[i])));
        end
    end

    // ---------------- X4..X6: true_up = left x forward ----------------
    logic                      x4_v_reg, x5_v_reg, x6_v_reg;
    logic signed [IN_BITS-1:0] x4_from_reg [3];
    logic signed [IN_BITS-1:0] x5_from_reg [3];
    logic signed [IN_BITS-1:0] x6_from_reg [3];
    logic signed [UW-1:0]      x4_fwd_reg [3];
    logic signed [UW-1:0]      x5_fwd_reg [3];
    logic signed [RW-1:0]      x4_r0_reg [3];
    logic signed [RW-1:0]      x5_r0_reg [3];
    logic signed [P2_W-1:0]    x4_p_reg [6];
    logic signed [D2_W-1:0]    x5_raw_reg [3];
    logic signed [RW-1:0]      x6_row_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x4_v_reg <= 1'b0;
            x5_v_reg <= 1'b0;
            x6_v_reg <= 1'b0;
        end
        else if (en)
        begin
            x4_v_reg <= x3_v_reg;
            x5_v_reg <= x4_v_reg;
            x6_v_reg <= x5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x4_from_reg <= x3_from_reg;
            x4_fwd_reg  <= x3_fwd_reg;
            x4_r0_reg   <= x3_r0_reg;
            x4_p_reg[0] <= P2_W'(x3_r0_reg[1]) * P2_W'(x3_fwd_reg[2]);
            x4_p_reg[1] <= P2_W'(x3_r0_reg[2]) * P2_W'(x3_fwd_reg[1]);
            x4_p_reg[2] <= P2_W'(x3_r0_reg[2]) * P2_W'(x3_fwd_reg[0]);
            x4_p_reg[3] <= P2_W'(x3_r0_reg[0]) * P2_W'(x3_fwd_reg[2]);
            x4_p_reg[4] <= P2_W'(x3_r0_reg[0]) * P2_W'(x3_fwd_reg[1]);
            x4_p_reg[5] <= P2_W'(x3_r0_reg[1]) * P2_W'(x3_fwd_reg[0]);

            x5_from_reg <= x4_from_reg;
            x5_fwd_reg  <= x4_fwd_reg;
            x5_r0_reg   <= x4_r0_reg;
            for (int i = 0; i < 3; i++)
                x5_raw_reg[i] <= D2_W'(x4_p_reg[2*i]) - D2_W'(x4_p_reg[2*i+1]);

            x6_from_reg <= x5_from_reg;
            for (int i = 0; i < 3; i++)
            begin
                x6_row_reg[0][i] <= x5_r0_reg[i];
                x6_row_reg[1][i] <= RW'(rnd(RND_W'(x5_raw_reg[i])));
                x6_row_reg[2][i] <= -RW'(x5_fwd_reg[i]);
            end
        end
    end

    // ---------------- X7..X8: translation products ----------------
    logic                   x7_v_reg, x8_v_reg;
    logic signed [RW-1:0]   x7_row_reg [3][3];
    logic signed [RW-1:0]   x8_row_reg [3][3];
    logic signed [P3_W-1:0] x7_p_reg [3][3];
    logic signed [C3_W-1:0] x8_rp_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x7_v_reg <= 1'b0;
            x8_v_reg <= 1'b0;
        end
        else if (en)
        begin
            x7_v_reg <= x6_v_reg;
            x8_v_reg <= x7_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x7_row_reg <= x6_row_reg;
            x8_row_reg <= x7_row_reg;
            for (int r = 0; r < 3; r++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    x7_p_reg[r][j]  <= P3_W'(x6_row_reg[r][j]) * P3_W'(x6_from_reg[j]);
                    x8_rp_reg[r][j] <= C3_W'(rnd(RND_W'(x7_p_reg[r][j])));
                end
            end
        end
    end

    // ---------------- row buffer: saturate, emit one row per beat ----------------
    logic signed [WORD_WIDTH-1:0] buf_col_reg [3][3];
    logic signed [WORD_WIDTH-1:0] buf_c3_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            buf_row_reg   <= ROW_FIRST;
        end
        else if (en)
        begin
            buf_valid_reg <= x8_v_reg;
            buf_row_reg   <= ROW_FIRST;
        end
        else if (!out_stall)
        begin
            buf_row_reg <= buf_row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int j = 0; j < 3; j++)
                    buf_col_reg[r][j] <= sat(SAT_W'(x8_row_reg[r][j]));
                buf_c3_reg[r] <= sat(-(SAT_W'(x8_rp_reg[r][0]) + SAT_W'(x8_rp_reg[r][1])
                                     + SAT_W'(x8_rp_reg[r][2])));
            end
        end
    end

    assign out_valid = buf_valid_reg;
    assign row_index = buf_row_reg;
    assign last_row  = (buf_row_reg == ROW_LAST);

    always_comb
    begin
        case (buf_row_reg)
            2'd0, 2'd1, 2'd2:
            begin
                col_zero  = buf_col_reg[buf_row_reg][0];
                col_one   = buf_col_reg[buf_row_reg][1];
                col_two   = buf_col_reg[buf_row_reg][2];
                col_three = buf_c3_reg[buf_row_reg];
            end
            default:
            begin
                col_zero  = '0;
                col_one   = '0;
                col_two   = '0;
                col_three = sat(ONE_FX);
            end
        endcase
    end

    // ---------------- assertions ----------------
    // rows of one matrix leave back to back, no gap once row 0 went out
    a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && buf_row_reg != ROW_LAST) |=> out_valid)
        else $error("row run broken before last row");

    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && buf_row_reg != ROW_LAST)
        |=> (buf_row_reg == $past(buf_row_reg) + 2'd1))
        else $error("row index did not advance by one");

    a_new_item_row0: assert property (@(posedge clk) disable iff (!rst_n)
        (en && x8_v_reg) |=> (out_valid && buf_row_reg == ROW_FIRST))
        else $error("new matrix did not start at row 0");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && out_valid) |-> (!out_stall && last_row))
        else $error("input taken while row buffer still busy");

endmodule

/* tb/look_at_view_matrix_checker.sv */
// Checker for look_at_view_matrix_top: watches both channels, predicts the four
// matrix rows for each accepted camera beat, and compares rows as they leave.
// Depends on lav_pkg.
`timescale 1ns / 1ps

module look_at_view_matrix_checker
    import lav_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [IN_BITS-1:0]    from_x,
    input  logic signed [IN_BITS-1:0]    from_y,
    input  logic signed [IN_BITS-1:0]    from_z,
    input  logic signed [IN_BITS-1:0]    to_x,
    input  logic signed [IN_BITS-1:0]    to_y,
    input  logic signed [IN_BITS-1:0]    to_z,
    input  logic signed [IN_BITS-1:0]    up_x,
    input  logic signed [IN_BITS-1:0]    up_y,
    input  logic signed [IN_BITS-1:0]    up_z,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [1:0]                   row_index,
    input  logic signed [WORD_WIDTH-1:0] col_zero,
    input  logic signed [WORD_WIDTH-1:0] col_one,
    input  logic signed [WORD_WIDTH-1:0] col_two,
    input  logic signed [WORD_WIDTH-1:0] col_three,
    input  logic                         last_row,
    output int                           fail_count,
    output int                           rows_pending
);

    typedef struct {
        logic [1:0]                   row;
        logic signed [WORD_WIDTH-1:0] c0;
        logic signed [WORD_WIDTH-1:0] c1;
        logic signed [WORD_WIDTH-1:0] c2;
        logic signed [WORD_WIDTH-1:0] c3;
        logic                         last;
    } matrix_row_t;

    matrix_row_t pending_rows[$];

    localparam longint SAT_HI = (longint'(1) <<< (WORD_WIDTH - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    function automatic longint rnd_shift(input longint v);
        longint half;
        half = longint'(1) <<< (FRAC_BITS - 1);
        if (v >= 0)
            return (v + half) >>> FRAC_BITS;
        return -((-v + half) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [WORD_WIDTH-1:0] clamp_word(input longint v);
        if (v > SAT_HI)
            v = SAT_HI;
        else if (v < SAT_LO)
            v = SAT_LO;
        return v[WORD_WIDTH-1:0];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic void unit_vec(input longint v[3], output longint o[3]);
        longint unsigned mg[3];
        longint unsigned top, sum, len, q;
        top = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mg[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mg[i] > top)
                top = mg[i];
        end
        if (top == 0)
        begin
            o[0] = 0;
            o[1] = 0;
            o[2] = 0;
            return;
        end
        while (top >= (64'd1 << MG_W))
        begin
            top = top >> 1;
            for (int i = 0; i < 3; i++)
                mg[i] = mg[i] >> 1;
        end
        while (top < (64'd1 << (MG_W - 1)))
        begin
            top = top << 1;
            for (int i = 0; i < 3; i++)
                mg[i] = mg[i] << 1;
        end
        for (int i = 0; i < 3; i++)
            sum = sum + mg[i] * mg[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mg[i] << FRAC_BITS) + (len >> 1)) / len;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3], output longint o[3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    task automatic push_view_rows();
        longint pos[3], dir[3], up[3], fwd[3], upn[3], raw[3];
        longint rows[3][3];
        longint acc;
        matrix_row_t r;
        pos[0] = longint'(from_x);
        pos[1] = longint'(from_y);
        pos[2] = longint'(from_z);
        dir[0] = longint'(to_x) - pos[0];
        dir[1] = longint'(to_y) - pos[1];
        dir[2] = longint'(to_z) - pos[2];
        up[0]  = longint'(up_x);
        up[1]  = longint'(up_y);
        up[2]  = longint'(up_z);
        unit_vec(up, upn);
        unit_vec(dir, fwd);
        cross3(fwd, upn, raw);
        // degenerate cross: fall back to +z up
        if (raw[0] == 0 && raw[1] == 0 && raw[2] == 0)
        begin
            upn[0] = 0;
            upn[1] = 0;
            upn[2] = longint'(1) <<< FRAC_BITS;
            cross3(fwd, upn, raw);
        end
        for (int j = 0; j < 3; j++)
            rows[0][j] = rnd_shift(raw[j]);
        cross3(rows[0], fwd, raw);
        for (int j = 0; j < 3; j++)
        begin
            rows[1][j] = rnd_shift(raw[j]);
            rows[2][j] = -fwd[j];
        end
        for (int k = 0; k < 3; k++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += rnd_shift(rows[k][j] * pos[j]);
            r.row  = k[1:0];
            r.c0   = clamp_word(rows[k][0]);
            r.c1   = clamp_word(rows[k][1]);
            r.c2   = clamp_word(rows[k][2]);
            r.c3   = clamp_word(-acc);
            r.last = 1'b0;
            pending_rows.push_back(r);
        end
        r.row  = ROW_LAST;
        r.c0   = '0;
        r.c1   = '0;
        r.c2   = '0;
        r.c3   = clamp_word(longint'(1) <<< FRAC_BITS);
        r.last = 1'b1;
        pending_rows.push_back(r);
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
        fail_count = 0;

    assign rows_pending = pending_rows.size();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                push_view_rows();
            if (out_valid && !out_stall)
            begin
                if (pending_rows.size() == 0)
                begin
                    $error("row beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    matrix_row_t e;
                    e = pending_rows.pop_front();
                    check_field("row_index", e.row, row_index);
                    check_field("col_zero", e.c0, col_zero);
                    check_field("col_one", e.c1, col_one);
                    check_field("col_two", e.c2, col_two);
                    check_field("col_three", e.c3, col_three);
                    check_field("last_row", e.last, last_row);
                end
            end
        end
    end

endmodule

/* tb/look_at_view_matrix_top_tb.sv */
// Testbench top for look_at_view_matrix_top: clock, reset, camera stimulus,
// output stall patterns, watchdog and verdict. Depends on lav_pkg and the checker.
`timescale 1ns / 1ps

module look_at_view_matrix_top_tb;
    import lav_pkg::*;

    localparam int WORD_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int N_RANDOM    = 470;
    localparam int IDLE_LIMIT  = 5000;
    localparam int LONG_HOLD   = 400;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [IN_BITS-1:0] from_x, from_y, from_z;
    logic signed [IN_BITS-1:0] to_x, to_y, to_z;
    logic signed [IN_BITS-1:0] up_x, up_y, up_z;
    logic out_valid;
    logic out_stall;
    logic [1:0] row_index;
    logic signed [WORD_WIDTH-1:0] col_zero, col_one, col_two, col_three;
    logic last_row;
    int fail_count;
    int rows_pending;
    int idle_cycles;
    logic hold_req;

    look_at_view_matrix_top #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .from_x(from_x), .from_y(from_y), .from_z(from_z),
        .to_x(to_x), .to_y(to_y), .to_z(to_z),
        .up_x(up_x), .up_y(up_y), .up_z(up_z),
        .out_valid(out_valid), .out_stall(out_stall), .row_index(row_index),
        .col_zero(col_zero), .col_one(col_one), .col_two(col_two),
        .col_three(col_three), .last_row(last_row)
    );

    look_at_view_matrix_checker #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) i_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .from_x(from_x), .from_y(from_y), .from_z(from_z),
        .to_x(to_x), .to_y(to_y), .to_z(to_z),
        .up_x(up_x), .up_y(up_y), .up_z(up_z),
        .out_valid(out_valid), .out_stall(out_stall), .row_index(row_index),
        .col_zero(col_zero), .col_one(col_one), .col_two(col_two),
        .col_three(col_three), .last_row(last_row),
        .fail_count(fail_count), .rows_pending(rows_pending)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0, 1: return $urandom;
            2:
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                3: return 32'h0001_0000;
                default: return 32'hffff_0000;
            endcase
            3: return $urandom_range(0, 255) - 128;
            default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    // one camera beat; returns after acceptance with the beat still on the bus
    task automatic send_camera(input logic [31:0] f[3], input logic [31:0] t[3],
                               input logic [31:0] u[3]);
        @(negedge clk);
        from_x = f[0]; from_y = f[1]; from_z = f[2];
        to_x = t[0]; to_y = t[1]; to_z = t[2];
        up_x = u[0]; up_y = u[1]; up_z = u[2];
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_random_camera();
        logic [31:0] f[3], t[3], u[3];
        int kind;
        for (int i = 0; i < 3; i++)
        begin
            f[i] = pick_coord();
            t[i] = pick_coord();
            u[i] = pick_coord();
        end
        kind = $urandom_range(0, 9);
        if (kind == 0)
            t = f;                          // coincident points
        else if (kind == 1)
            u = '{0, 0, 0};                 // zero up
        else if (kind == 2)
            for (int i = 0; i < 3; i++)     // up parallel to forward
                u[i] = t[i] - f[i];
        send_camera(f, t, u);
    endtask

    // receiver: stall pattern changes every so often; one long hold on request
    initial
    begin
        int mode;
        bit held;
        out_stall = 1'b0;
        mode = 0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                held = 1'b1;
            end
            if ($urandom_range(0, 150) == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: out_stall = 1'b0;
                1: out_stall = $urandom_range(0, 1);
                2: out_stall = ($urandom_range(0, 3) != 0);
                default: out_stall = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("look_at_view_matrix_top_tb failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] f[3], t[3], u[3];
        int burst;
        rst_n = 1'b0;
        in_valid = 1'b0;
        hold_req = 1'b0;
        from_x = '0; from_y = '0; from_z = '0;
        to_x = '0; to_y = '0; to_z = '0;
        up_x = '0; up_y = '0; up_z = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: textbook camera, extremes, degenerate cases
        send_camera('{0, 0, 32'h000a_0000}, '{0, 0, 0}, '{0, 32'h0001_0000, 0});
        send_camera('{32'h0001_0000, 32'h0002_0000, 32'h0003_0000},
                    '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000},
                    '{0, 32'h0001_0000, 0});
        send_camera('{0, 0, 0}, '{32'h0001_0000, 0, 0}, '{0, 0, 0});
        send_camera('{0, 0, 0}, '{0, 0, 32'h0005_0000}, '{0, 0, 32'h0001_0000});
        send_camera('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
        send_camera('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                    '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
                    '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001});
        send_camera('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},
                    '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000},
                    '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        send_camera('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
                    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                    '{32'h0000_0001, 0, 0});
        send_camera('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, '{0, 0, 0},
                    '{32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff});
        send_camera('{32'h0000_0001, 0, 0}, '{0, 0, 0}, '{32'h8000_0000, 0, 0});
        send_camera('{32'h0123_4567, 32'hfedc_ba98, 32'h0f0f_0f0f},
                    '{32'hf0f0_f0f0, 32'h5555_5555, 32'haaaa_aaaa},
                    '{32'h0000_0003, 32'hffff_fffd, 32'h0000_0007});
        send_camera('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
                    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                    '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
        idle_gap(1);

        // sender pauses until every row of the directed part has left
        wait (rows_pending == 0);

        for (int n = 0; n < N_RANDOM; )
        begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++)
            begin
                if (n == 150)
                    hold_req = 1'b1;        // block fills while the sender keeps going
                if (n == 320)
                begin
                    idle_gap(1);
                    wait (rows_pending == 0);
                end
                send_random_camera();
            end
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 12));
        end
        idle_gap(1);

        wait (rows_pending == 0);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("look_at_view_matrix_top_tb passed");
        else
            $display("look_at_view_matrix_top_tb failed");
        $finish;
    end

endmodule

/* filelist.f */
design/lav_pkg.sv
design/look_at_view_matrix_top.sv
tb/look_at_view_matrix_checker.sv
tb/look_at_view_matrix_top_tb.sv
